// ----- hdl/bbfp_pkg.sv -----
package bbfp_pkg;

  localparam int unsigned CaptureDepth = 18;
  localparam int unsigned CaptureIdxW  = 5;

  localparam logic [7:0] AdService16  = 8'h16;
  localparam logic [7:0] UuidLoByte   = 8'hAA;
  localparam logic [7:0] UuidHiByte   = 8'hFE;
  localparam logic [7:0] KindIdType   = 8'h00;
  localparam logic [7:0] KindTlmType  = 8'h20;
  localparam logic [7:0] TlmVersion   = 8'h00;
  localparam logic [7:0] MinStructLen = 8'd3;
  // service bytes + type + 2 UUID bytes
  localparam logic [7:0] IdMinLen     = 8'd23;
  localparam logic [7:0] TlmMinLen    = 8'd17;
  localparam logic [7:0] OffsetMax    = 8'd255;

  typedef enum logic [1:0] {
    CAND_NONE = 2'd0,
    CAND_ID   = 2'd1,
    CAND_TLM  = 2'd2
  } cand_kind_t;

  localparam logic KindId  = 1'b0;
  localparam logic KindTlm = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic               found_frame;
    logic               frame_kind;
    logic [15:0]        namespace_high;
    logic [63:0]        namespace_low;
    logic [47:0]        instance_code;
    logic [15:0]        battery_millivolts;
    logic signed [15:0] temperature_q8_8;
  } out_item_t;

endpackage

// ----- hdl/ble_beacon_frame_parser_core.sv -----
// channel | dir | handshake           | payload
// --------+-----+---------------------+------------------------------
// in      | in  | in_valid / in_stall | in_data      (data_byte, last_byte)
// out     | out | out_valid/out_stall | frame_result (beacon result)
//
// One byte per cycle sustained: input register, one pass of parse logic,
// result register. out_valid is set as the last byte leaves the input register.
// Non-final bytes keep flowing while a result waits; a final byte holds in
// the input register until the result register is free.
// Synchronous reset returns the parser to expecting a length byte.
module ble_beacon_frame_parser_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bbfp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bbfp_pkg::out_item_t frame_result
);
  import bbfp_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN, PH_TYPE, PH_UUID_LO, PH_UUID_HI, PH_SERVICE, PH_SKIP, PH_STOPPED, PH_DONE
  } phase_t;

  logic       in_q_valid;
  in_item_t   in_q;
  logic       advance;

  phase_t     phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] service_offset, service_offset_next;
  logic [7:0] struct_length, struct_length_next;
  cand_kind_t cand, cand_next;
  logic       res_valid, res_valid_next;

  logic [7:0] capture [CaptureDepth];
  logic [7:0] capv    [CaptureDepth];
  logic       cap_we;

  out_item_t  res, res_next;
  out_item_t  out_next;
  logic [7:0] b;

  assign b        = in_q.data_byte;
  assign advance  = in_q_valid && (!in_q.last_byte || !out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  always_comb begin
    for (int i = 0; i < CaptureDepth; i++) begin
      capv[i] = (cap_we && service_offset[CaptureIdxW-1:0] == CaptureIdxW'(i)) ? b : capture[i];
    end
  end

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    service_offset_next = service_offset;
    struct_length_next  = struct_length;
    cand_next           = cand;
    res_valid_next      = res_valid;
    res_next            = res;
    cap_we              = 1'b0;
    out_next            = '0;

    case (phase)
      PH_LEN: begin
        if (b == 8'd0) begin
          phase_next = PH_STOPPED;
        end else begin
          struct_length_next  = b;
          bytes_left_next     = b;
          service_offset_next = 8'd0;
          cand_next           = CAND_NONE;
          phase_next          = (b < MinStructLen) ? PH_SKIP : PH_TYPE;
        end
      end
      PH_TYPE, PH_UUID_LO, PH_UUID_HI, PH_SERVICE, PH_SKIP: begin
        bytes_left_next = bytes_left - 8'd1;
        case (phase)
          PH_TYPE:    phase_next = (b == AdService16) ? PH_UUID_LO : PH_SKIP;
          PH_UUID_LO: phase_next = (b == UuidLoByte) ? PH_UUID_HI : PH_SKIP;
          PH_UUID_HI: phase_next = (b == UuidHiByte) ? PH_SERVICE : PH_SKIP;
          PH_SERVICE: begin
            if (service_offset == 8'd0) begin
              cand_next = (b == KindIdType)  ? CAND_ID  :
                          (b == KindTlmType) ? CAND_TLM : CAND_NONE;
            end
            cap_we = (service_offset < 8'(CaptureDepth));
            if (service_offset < OffsetMax) begin
              service_offset_next = service_offset + 8'd1;
            end
          end
          default: ;
        endcase
        if (bytes_left_next == 8'd0) begin
          if (phase_next == PH_SERVICE && service_offset_next != 8'd0) begin
            if (cand_next == CAND_ID && struct_length >= IdMinLen) begin
              res_next                = '0;
              res_next.found_frame    = 1'b1;
              res_next.frame_kind     = KindId;
              res_next.namespace_high = {capv[2], capv[3]};
              res_next.namespace_low  = {capv[4], capv[5], capv[6], capv[7],
                                         capv[8], capv[9], capv[10], capv[11]};
              res_next.instance_code  = {capv[12], capv[13], capv[14],
                                         capv[15], capv[16], capv[17]};
              res_valid_next          = 1'b1;
            end else if (cand_next == CAND_TLM && struct_length >= TlmMinLen &&
                         capv[1] == TlmVersion) begin
              res_next                    = '0;
              res_next.found_frame        = 1'b1;
              res_next.frame_kind         = KindTlm;
              res_next.battery_millivolts = {capv[2], capv[3]};
              res_next.temperature_q8_8   = {capv[4], capv[5]};
              res_valid_next              = 1'b1;
            end
          end
          phase_next = res_valid_next ? PH_DONE : PH_LEN;
        end
      end
      default: ;
    endcase

    if (res_valid_next) begin
      out_next = res_next;
    end

    if (in_q.last_byte) begin
      phase_next          = PH_LEN;
      bytes_left_next     = 8'd0;
      service_offset_next = 8'd0;
      struct_length_next  = 8'd0;
      cand_next           = CAND_NONE;
      res_valid_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid     <= 1'b0;
      out_valid      <= 1'b0;
      phase          <= PH_LEN;
      bytes_left     <= 8'd0;
      service_offset <= 8'd0;
      struct_length  <= 8'd0;
      cand           <= CAND_NONE;
      res_valid      <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_q_valid <= 1'b1;
      end else if (advance) begin
        in_q_valid <= 1'b0;
      end
      if (advance && in_q.last_byte) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        phase          <= phase_next;
        bytes_left     <= bytes_left_next;
        service_offset <= service_offset_next;
        struct_length  <= struct_length_next;
        cand           <= cand_next;
        res_valid      <= res_valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
    if (advance) begin
      res <= res_next;
      if (cap_we) begin
        capture[service_offset[CaptureIdxW-1:0]] <= b;
      end
      if (in_q.last_byte) begin
        frame_result <= out_next;
      end
    end
  end

endmodule

// ----- dv/beacon_result_check.sv -----
`timescale 1ns / 1ps
module beacon_result_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  bbfp_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  bbfp_pkg::out_item_t frame_result,
  output int unsigned         errors,
  output int unsigned         pending,
  output int unsigned         checked,
  output int unsigned         id_frames,
  output int unsigned         tlm_frames
);
  import bbfp_pkg::*;

  typedef enum logic [2:0] {
    W_LEN, W_TYPE, W_UUID_LO, W_UUID_HI, W_SVC, W_SKIP, W_STOP, W_DONE
  } walk_t;

  walk_t      walk;
  logic [7:0] left;
  logic [7:0] svc_idx;
  logic [7:0] slen;
  logic [7:0] cap [CaptureDepth];
  cand_kind_t cand;
  logic       kept;
  out_item_t  held;
  out_item_t  due;
  out_item_t  frames_due [$];

  int unsigned nerr = 0;
  int unsigned ndone = 0;
  int unsigned nid = 0;
  int unsigned ntlm = 0;

  task automatic report(input string msg);
    $display("%0t check: %s", $time, msg);
    nerr++;
  endtask

  task automatic match(input string name, input logic [63:0] got, input logic [63:0] exp_v);
    if (got !== exp_v) begin
      report($sformatf("%s got %h expected %h", name, got, exp_v));
    end
  endtask

  task automatic clear_walk();
    walk    = W_LEN;
    left    = '0;
    svc_idx = '0;
    slen    = '0;
    cand    = CAND_NONE;
    kept    = 1'b0;
    held    = '0;
    for (int i = 0; i < CaptureDepth; i++) cap[i] = '0;
  endtask

  // advance the structure walk by one byte; queue the frame on the final byte
  task automatic take_byte(input in_item_t it);
    logic [7:0] b;
    b = it.data_byte;
    if (walk == W_LEN) begin
      if (b == 8'd0) begin
        walk = W_STOP;
      end else begin
        slen    = b;
        left    = b;
        svc_idx = '0;
        cand    = CAND_NONE;
        walk    = (b < MinStructLen) ? W_SKIP : W_TYPE;
      end
    end else if (walk != W_STOP && walk != W_DONE) begin
      left = left - 8'd1;
      case (walk)
        W_TYPE:    walk = (b == AdService16) ? W_UUID_LO : W_SKIP;
        W_UUID_LO: walk = (b == UuidLoByte) ? W_UUID_HI : W_SKIP;
        W_UUID_HI: walk = (b == UuidHiByte) ? W_SVC : W_SKIP;
        W_SVC: begin
          if (svc_idx == 8'd0) begin
            cand = (b == KindIdType) ? CAND_ID : (b == KindTlmType) ? CAND_TLM : CAND_NONE;
          end
          if (svc_idx < CaptureDepth) cap[svc_idx[CaptureIdxW-1:0]] = b;
          if (svc_idx < OffsetMax) svc_idx = svc_idx + 8'd1;
        end
        default: ;
      endcase
      if (left == 8'd0) begin
        if (walk == W_SVC && svc_idx != 8'd0) begin
          if (cand == CAND_ID && slen >= IdMinLen) begin
            held                = '0;
            held.found_frame    = 1'b1;
            held.frame_kind     = KindId;
            held.namespace_high = {cap[2], cap[3]};
            held.namespace_low  = {cap[4], cap[5], cap[6], cap[7],
                                   cap[8], cap[9], cap[10], cap[11]};
            held.instance_code  = {cap[12], cap[13], cap[14], cap[15], cap[16], cap[17]};
            kept                = 1'b1;
          end else if (cand == CAND_TLM && slen >= TlmMinLen && cap[1] == TlmVersion) begin
            held                    = '0;
            held.found_frame        = 1'b1;
            held.frame_kind         = KindTlm;
            held.battery_millivolts = {cap[2], cap[3]};
            held.temperature_q8_8   = {cap[4], cap[5]};
            kept                    = 1'b1;
          end
        end
        walk = kept ? W_DONE : W_LEN;
      end
    end
    if (it.last_byte) begin
      frames_due.push_back(held);
      clear_walk();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_walk();
      frames_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          report("result transaction with no payload end waiting");
        end else begin
          due = frames_due.pop_front();
          match("found_frame", 64'(frame_result.found_frame), 64'(due.found_frame));
          match("frame_kind", 64'(frame_result.frame_kind), 64'(due.frame_kind));
          match("namespace_high", 64'(frame_result.namespace_high),
                64'(due.namespace_high));
          match("namespace_low", frame_result.namespace_low, due.namespace_low);
          match("instance_code", 64'(frame_result.instance_code), 64'(due.instance_code));
          match("battery_millivolts", 64'(frame_result.battery_millivolts),
                64'(due.battery_millivolts));
          match("temperature_q8_8", 64'($unsigned(frame_result.temperature_q8_8)),
                64'($unsigned(due.temperature_q8_8)));
          ndone++;
          if (due.found_frame && due.frame_kind == KindId) nid++;
          if (due.found_frame && due.frame_kind == KindTlm) ntlm++;
        end
      end
      if (in_valid && !in_stall) take_byte(in_data);
    end
    errors     <= nerr;
    pending    <= $unsigned(frames_due.size());
    checked    <= ndone;
    id_frames  <= nid;
    tlm_frames <= ntlm;
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import bbfp_pkg::*;

  localparam int FillRand = 0;
  localparam int FillZero = 1;
  localparam int FillOnes = 2;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t frame_result;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned id_frames;
  int unsigned tlm_frames;

  int unsigned bytes_sent = 0;
  int unsigned payloads = 0;
  int unsigned stall_hold = 0;
  int unsigned cyc = 0;
  int          svc_base = 0;
  bit          calm = 1'b0;
  logic [7:0]  payload [$];

  always #2 clk = ~clk;

  ble_beacon_frame_parser_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_result (frame_result)
  );

  beacon_result_check i_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_result (frame_result),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked),
    .id_frames    (id_frames),
    .tlm_frames   (tlm_frames)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // stall bursts with a periodic quiet window
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall || cyc % 1024 < 200) begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 6);
    end else begin
      out_stall  <= 1'b1;
      stall_hold <= gap_len();
    end
  end

  task automatic add_service(input int svc, input logic [7:0] ftype,
                             input logic [7:0] second, input int fill);
    payload.push_back(8'(svc + 3));
    payload.push_back(AdService16);
    payload.push_back(UuidLoByte);
    payload.push_back(UuidHiByte);
    svc_base = payload.size();
    for (int i = 0; i < svc; i++) begin
      if (i == 0) payload.push_back(ftype);
      else if (i == 1) payload.push_back(second);
      else if (fill == FillZero) payload.push_back(8'h00);
      else if (fill == FillOnes) payload.push_back(8'hFF);
      else payload.push_back(8'($urandom));
    end
  endtask

  task automatic add_struct();
    int         r;
    int         n;
    int         k;
    logic [7:0] hdr [3];
    r = $urandom_range(0, 99);
    if (r < 28) begin
      add_service($urandom_range(20, 24), KindIdType, 8'($urandom), FillRand);
    end else if (r < 52) begin
      add_service($urandom_range(14, 18), KindTlmType,
                  ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : TlmVersion,
                  FillRand);
    end else if (r < 62) begin
      add_service($urandom_range(0, 19),
                  ($urandom_range(0, 1) == 0) ? KindIdType : KindTlmType,
                  TlmVersion, FillRand);
    end else if (r < 70) begin
      // service header with one byte spoilt
      n      = $urandom_range(1, 12);
      hdr[0] = AdService16;
      hdr[1] = UuidLoByte;
      hdr[2] = UuidHiByte;
      k      = $urandom_range(0, 2);
      hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
      payload.push_back(8'(n));
      for (int i = 0; i < n; i++) payload.push_back((i < 3) ? hdr[i] : 8'($urandom));
    end else if (r < 82) begin
      n = $urandom_range(1, 8);
      payload.push_back(8'(n));
      repeat (n) payload.push_back(8'($urandom));
    end else if (r < 87) begin
      payload.push_back(8'h00);
      repeat ($urandom_range(0, 5)) payload.push_back(8'($urandom));
    end else if (r < 93) begin
      repeat ($urandom_range(1, 4)) payload.push_back(8'($urandom));
    end else begin
      add_service($urandom_range(20, 60), KindIdType, 8'($urandom), FillRand);
    end
  endtask

  task automatic send_payload();
    int g;
    for (int i = 0; i < payload.size(); i++) begin
      g = calm ? 0 : gap_len();
      if (g != 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= {payload[i], i == payload.size() - 1};
      do @(posedge clk); while (in_stall);
      bytes_sent++;
    end
    payloads++;
    payload.delete();
  endtask

  initial begin
    int          keep;
    logic [7:0]  lead [8] = '{8'h02, 8'h01, 8'h06, 8'h01, 8'hC3, 8'h02, 8'h16, 8'hAA};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    payload.push_back(8'h00);
    send_payload();
    payload.push_back(8'hFF);
    send_payload();
    add_service(20, KindIdType, 8'hFF, FillOnes);
    send_payload();
    add_service(20, KindIdType, 8'h00, FillZero);
    send_payload();
    add_service(19, KindIdType, 8'h00, FillRand);
    add_service(14, KindTlmType, TlmVersion, FillOnes);
    payload[svc_base + 4] = 8'h80;
    payload[svc_base + 5] = 8'h00;
    send_payload();
    add_service(13, KindTlmType, TlmVersion, FillRand);
    add_service(14, KindTlmType, 8'h01, FillRand);
    add_service(14, KindTlmType, TlmVersion, FillZero);
    payload[svc_base + 4] = 8'h7F;
    payload[svc_base + 5] = 8'hFF;
    send_payload();
    // flags, lengths of one, two and three, then a good identifier
    foreach (lead[i]) payload.push_back(lead[i]);
    add_service(0, KindIdType, 8'h00, FillRand);
    add_service(21, KindIdType, 8'($urandom), FillRand);
    send_payload();
    payload.push_back(8'h00);
    add_service(20, KindIdType, 8'h00, FillRand);
    send_payload();
    add_service(22, KindIdType, 8'h00, FillRand);
    void'(payload.pop_back());
    send_payload();
    add_service(20, KindIdType, 8'h00, FillRand);
    add_service(14, KindTlmType, TlmVersion, FillRand);
    send_payload();
    add_service(20, KindIdType, 8'h00, FillRand);
    payload[svc_base - 1] = 8'hFF;
    add_service(20, KindIdType, 8'h00, FillRand);
    payload[svc_base - 3] = 8'h17;
    send_payload();

    while (bytes_sent < 1850) begin
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 3)) add_struct();
      if ($urandom_range(0, 9) == 0) begin
        keep = $urandom_range(1, payload.size());
        while (payload.size() > keep) void'(payload.pop_back());
      end
      send_payload();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    $display("tb: %0d bytes over %0d payloads, %0d results compared", bytes_sent, payloads,
             checked);
    $display("tb: frames found: %0d identifier, %0d telemetry", id_frames, tlm_frames);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
